// ----- src/gcb_pkg.sv -----
`default_nettype none

package gcb_pkg;

  // Field widths
  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 10;
  localparam int BEARING_BITS    = ANGLE_FRAC_BITS + 9;
  localparam int RES_BITS        = 32;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 3;

  // Leg products and their normalised form
  localparam int LEG_BITS   = COORD_BITS + RES_BITS;
  localparam int LEG_LIMIT  = 30;
  localparam int SHIFT_BITS = $clog2(LEG_BITS - LEG_LIMIT + 1);

  // CORDIC datapath: X/Y carry gain and sign headroom, Z in 2^-24 degree
  localparam int CORDIC_STEPS = 28;
  localparam int CW           = LEG_LIMIT + 3;
  localparam int ZFRAC        = 24;
  localparam int ZW           = 32;
  localparam int ROUND_SHIFT  = ZFRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] Z_LIMIT = ZW'(90 << ZFRAC);
  localparam logic signed [ZW-1:0] Z_HALF  = ZW'(1 << (ROUND_SHIFT - 1));

  // Fixed bearings
  localparam logic [BEARING_BITS-1:0] DEG_90  = BEARING_BITS'(90 << ANGLE_FRAC_BITS);
  localparam logic [BEARING_BITS-1:0] DEG_180 = BEARING_BITS'(180 << ANGLE_FRAC_BITS);
  localparam logic [BEARING_BITS-1:0] DEG_270 = BEARING_BITS'(270 << ANGLE_FRAC_BITS);
  localparam logic [BEARING_BITS-1:0] DEG_360 = BEARING_BITS'(360 << ANGLE_FRAC_BITS);

  localparam logic [RES_BITS-1:0] RES_RESET = RES_BITS'(65536);

  // atan(2^-i) in 2^-24 degree, rounded to nearest
  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7
  };

  // Configuration register indices
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CENTRE_ROW = 3'd0,
    REG_CENTRE_COL = 3'd1,
    REG_EW_RES     = 3'd2,
    REG_NS_RES     = 3'd3,
    REG_REVERSE    = 3'd4
  } gcb_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] cell_row;
    logic [COORD_BITS-1:0] cell_col;
  } gcb_in_t;

  typedef struct packed {
    logic [BEARING_BITS-1:0] bearing;
    logic                    at_centre;
  } gcb_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] centre_row;
    logic [COORD_BITS-1:0] centre_col;
    logic [RES_BITS-1:0]   ew_res;
    logic [RES_BITS-1:0]   ns_res;
    logic                  reverse;
  } gcb_cfg_t;

  // Per-item flags that ride alongside the angle datapath
  typedef struct packed {
    logic at_centre;
    logic row_zero;
    logic col_zero;
    logic row_neg;
    logic col_neg;
    logic x_zero;
    logic y_zero;
  } gcb_side_t;

endpackage

`default_nettype wire

// ----- src/gcb_legs.sv -----
`default_nettype none

module gcb_legs import gcb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  gcb_in_t              in_data,
  input  gcb_cfg_t             cfg,
  output logic                 out_valid,
  output gcb_side_t            out_side,
  output logic [LEG_LIMIT-1:0] cor_x,
  output logic [LEG_LIMIT-1:0] cor_y
);

  localparam int THERM_BITS = LEG_BITS - LEG_LIMIT;

  logic                  v1, v2, v3, v4, v5;
  gcb_side_t             s1, s2, s3, s4, s5;
  logic [COORD_BITS-1:0] ax1, ay1;
  logic [LEG_BITS-1:0]   x2, y2;
  logic [LEG_BITS-1:0]   x3, y3, m3;
  logic [LEG_BITS-1:0]   x4, y4;
  logic [SHIFT_BITS-1:0] sh4;
  logic [LEG_LIMIT-1:0]  xn5, yn5;

  // Stage 1 differences, taken both ways and selected
  logic [COORD_BITS-1:0] row_up, row_dn, col_up, col_dn;
  logic                  row_neg, col_neg;
  gcb_side_t             side_next;

  always_comb begin
    row_up  = in_data.cell_row - cfg.centre_row;
    row_dn  = cfg.centre_row - in_data.cell_row;
    col_up  = in_data.cell_col - cfg.centre_col;
    col_dn  = cfg.centre_col - in_data.cell_col;
    row_neg = in_data.cell_row < cfg.centre_row;
    col_neg = in_data.cell_col < cfg.centre_col;
    side_next.row_zero  = in_data.cell_row == cfg.centre_row;
    side_next.col_zero  = in_data.cell_col == cfg.centre_col;
    side_next.at_centre = side_next.row_zero && side_next.col_zero;
    side_next.row_neg   = row_neg;
    side_next.col_neg   = col_neg;
    side_next.x_zero    = 1'b0;
    side_next.y_zero    = 1'b0;
  end

  // Stage 4 normalising shift: count of leading bit positions above the limit in use
  logic [THERM_BITS-1:0] therm;
  logic [SHIFT_BITS-1:0] sh_next;

  always_comb begin
    for (int j = 0; j < THERM_BITS; j++) begin
      therm[j] = (m3 >> (LEG_LIMIT + j)) != '0;
    end
    sh_next = SHIFT_BITS'($countones(therm));
  end

  logic [LEG_BITS-1:0] xs5, ys5;
  assign xs5 = x4 >> sh4;
  assign ys5 = y4 >> sh4;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: absolute differences
      ax1 <= col_neg ? col_dn : col_up;
      ay1 <= row_neg ? row_dn : row_up;
      s1  <= side_next;
      // stage 2: scale by cell size
      x2 <= LEG_BITS'(ax1) * LEG_BITS'(cfg.ew_res);
      y2 <= LEG_BITS'(ay1) * LEG_BITS'(cfg.ns_res);
      s2 <= s1;
      // stage 3: larger leg and zero checks
      x3 <= x2;
      y3 <= y2;
      m3 <= (x2 > y2) ? x2 : y2;
      s3 <= '{at_centre: s2.at_centre, row_zero: s2.row_zero, col_zero: s2.col_zero,
              row_neg: s2.row_neg, col_neg: s2.col_neg,
              x_zero: x2 == '0, y_zero: y2 == '0};
      // stage 4: shift amount
      x4  <= x3;
      y4  <= y3;
      sh4 <= sh_next;
      s4  <= s3;
      // stage 5: normalised legs
      xn5 <= xs5[LEG_LIMIT-1:0];
      yn5 <= ys5[LEG_LIMIT-1:0];
      s5  <= s4;
    end
  end

  // CORDIC starts with X on the north-south leg, Y on the east-west leg
  assign out_valid = v5;
  assign out_side  = s5;
  assign cor_x     = yn5;
  assign cor_y     = xn5;

endmodule

`default_nettype wire

// ----- src/gcb_cordic.sv -----
`default_nettype none

module gcb_cordic import gcb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  gcb_side_t            in_side,
  input  logic [LEG_LIMIT-1:0] x0,
  input  logic [LEG_LIMIT-1:0] y0,
  output logic                 out_valid,
  output gcb_side_t            out_side,
  output logic signed [ZW-1:0] z
);

  // Stage registers, one rotation each
  logic signed [CW-1:0] xs [CORDIC_STEPS];
  logic signed [CW-1:0] ys [CORDIC_STEPS];
  logic signed [ZW-1:0] zs [CORDIC_STEPS];
  logic                 vs [CORDIC_STEPS];
  gcb_side_t            ss [CORDIC_STEPS];

  // Stage inputs
  logic signed [CW-1:0] xi [CORDIC_STEPS];
  logic signed [CW-1:0] yi [CORDIC_STEPS];
  logic signed [ZW-1:0] zi [CORDIC_STEPS];
  logic                 vi [CORDIC_STEPS];
  gcb_side_t            si [CORDIC_STEPS];

  always_comb begin
    xi[0] = $signed(CW'(x0));
    yi[0] = $signed(CW'(y0));
    zi[0] = '0;
    vi[0] = in_valid;
    si[0] = in_side;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      xi[i] = xs[i-1];
      yi[i] = ys[i-1];
      zi[i] = zs[i-1];
      vi[i] = vs[i-1];
      si[i] = ss[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORDIC_STEPS; i++) vs[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < CORDIC_STEPS; i++) vs[i] <= vi[i];
    end
  end

  // Vectoring: rotate Y towards zero, accumulate the angle turned
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        ss[i] <= si[i];
        if (!yi[i][CW-1]) begin
          xs[i] <= xi[i] + (yi[i] >>> i);
          ys[i] <= yi[i] - (xi[i] >>> i);
          zs[i] <= zi[i] + ZW'(ATAN_TAB[i]);
        end else begin
          xs[i] <= xi[i] - (yi[i] >>> i);
          ys[i] <= yi[i] + (xi[i] >>> i);
          zs[i] <= zi[i] - ZW'(ATAN_TAB[i]);
        end
      end
    end
  end

  assign out_valid = vs[CORDIC_STEPS-1];
  assign out_side  = ss[CORDIC_STEPS-1];
  assign z         = zs[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ----- src/gcb_place.sv -----
`default_nettype none

module gcb_place import gcb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 reverse,
  input  logic                 in_valid,
  input  gcb_side_t            in_side,
  input  logic signed [ZW-1:0] z,
  output logic                 out_valid,
  output gcb_out_t             out_data
);

  logic                    v1, v2, v3;
  gcb_side_t               s1;
  logic [BEARING_BITS-1:0] a1;
  logic [BEARING_BITS-1:0] b2;
  logic                    at2;
  gcb_out_t                o3;

  // Clamp to a quarter turn and round to output units
  logic signed [ZW-1:0]    zr;
  logic [BEARING_BITS-1:0] alpha_next;

  assign zr = z + Z_HALF;

  always_comb begin
    priority if (in_side.x_zero) alpha_next = '0;
    else if (in_side.y_zero)     alpha_next = DEG_90;
    else if (z[ZW-1])            alpha_next = '0;
    else if (z > Z_LIMIT)        alpha_next = DEG_90;
    else                         alpha_next = BEARING_BITS'(zr[ZW-1:ROUND_SHIFT]);
  end

  // Place in quadrant, forward sense
  logic [BEARING_BITS-1:0] b_next;

  always_comb begin
    priority if (s1.at_centre) b_next = '0;
    else if (s1.col_zero)      b_next = s1.row_neg ? '0 : DEG_180;
    else if (s1.row_zero)      b_next = s1.col_neg ? DEG_270 : DEG_90;
    else if (!s1.col_neg)      b_next = s1.row_neg ? a1 : DEG_180 - a1;
    else                       b_next = s1.row_neg ? DEG_360 - a1 : DEG_180 + a1;
  end

  // Reverse sense and wrap the full circle
  logic [BEARING_BITS:0]   bsum;
  logic [BEARING_BITS-1:0] bout;

  always_comb begin
    bsum = {1'b0, b2} + ((reverse && !at2) ? {1'b0, DEG_180} : '0);
    if (bsum >= {1'b0, DEG_360}) begin
      bout = BEARING_BITS'(bsum - {1'b0, DEG_360});
    end else begin
      bout = bsum[BEARING_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1           <= alpha_next;
      s1           <= in_side;
      b2           <= b_next;
      at2          <= s1.at_centre;
      o3.bearing   <= bout;
      o3.at_centre <= at2;
    end
  end

  assign out_valid = v3;
  assign out_data  = o3;

endmodule

`default_nettype wire

// ----- src/grid_cell_bearing_top.sv -----
// Compass bearing between a configured centre cell and a stream of raster cells.
//
// in_valid/in_ready/in_data carry one cell (row, column) per transaction;
// out_valid/out_ready/out_data return its bearing in 1/1024 degree, clockwise
// from north, with at_centre set (and bearing 0) when the cell is the centre.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the centre, the cell sizes and
// the reverse flag; cfg_ready is always high and writes belong to idle time.
//
// One cell is taken every cycle unless the pipeline is held by a stall. From input to
// output transaction, five stages form and normalise the legs (one of them the
// 32-bit resolution multiply), 28 stages run the CORDIC rotations one per
// stage, three place the angle in its quadrant and one is the output register.
//
// Reset empties the pipeline and restores the register defaults (centre 0,0,
// unit cell sizes, forward bearing). When the receiver stalls, a skid register
// behind the output register catches the one transaction still in flight; the
// whole pipeline then holds until the output drains, so nothing is lost.
`default_nettype none

module grid_cell_bearing_top import gcb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gcb_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gcb_out_t                  out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  gcb_cfg_t cfg;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_row <= '0;
      cfg.centre_col <= '0;
      cfg.ew_res     <= RES_RESET;
      cfg.ns_res     <= RES_RESET;
      cfg.reverse    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTRE_ROW: cfg.centre_row <= cfg_data[COORD_BITS-1:0];
        REG_CENTRE_COL: cfg.centre_col <= cfg_data[COORD_BITS-1:0];
        REG_EW_RES:     cfg.ew_res     <= cfg_data[RES_BITS-1:0];
        REG_NS_RES:     cfg.ns_res     <= cfg_data[RES_BITS-1:0];
        REG_REVERSE:    cfg.reverse    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: held only while the skid register is occupied
  logic     skid_valid;
  gcb_out_t skid_data;
  logic     adv;

  assign adv      = !skid_valid;
  assign in_ready = adv;

  logic                 leg_valid;
  gcb_side_t            leg_side;
  logic [LEG_LIMIT-1:0] leg_x, leg_y;

  gcb_legs u_legs (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (leg_valid),
    .out_side  (leg_side),
    .cor_x     (leg_x),
    .cor_y     (leg_y)
  );

  logic                 cor_valid;
  gcb_side_t            cor_side;
  logic signed [ZW-1:0] cor_z;

  gcb_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (leg_valid),
    .in_side   (leg_side),
    .x0        (leg_x),
    .y0        (leg_y),
    .out_valid (cor_valid),
    .out_side  (cor_side),
    .z         (cor_z)
  );

  logic     p_valid;
  gcb_out_t p_data;

  gcb_place u_place (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .reverse   (cfg.reverse),
    .in_valid  (cor_valid),
    .in_side   (cor_side),
    .z         (cor_z),
    .out_valid (p_valid),
    .out_data  (p_data)
  );

  // Output register with skid
  logic take;
  assign take = adv && p_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (take) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (take) skid_data <= p_data;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (take) begin
      out_data <= p_data;
    end
  end

`ifndef SYNTH
  // Skid only ever fills behind a stalled output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register occupied with output register empty");

  // A stalled skid keeps its transaction
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_valid && !out_ready |=> skid_valid)
    else $error("skid transaction dropped during stall");

  // Centre cell always reports bearing zero
  a_centre_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.at_centre |-> out_data.bearing == '0)
    else $error("centre cell with non-zero bearing");

  // Bearing is wrapped below a full circle
  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bearing < DEG_360)
    else $error("bearing not wrapped below 360 degrees");
`endif

endmodule

`default_nettype wire
